FILE: sv/uart_pkg.sv
// ----------------------------------------------------------------------------
// uart_pkg
// shared widths, register indexes and reset values of the 8n1 transceiver
// ----------------------------------------------------------------------------
package uart_pkg;

    localparam int unsigned TICK_W    = 16;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned BITCNT_W  = 4;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned IN_W      = 16;
    localparam int unsigned OUT_W     = 16;

    localparam logic [BITCNT_W-1:0] BITS_PER_BYTE = BITCNT_W'(BYTE_W);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TX_BIT_TICKS    = 2'd0,
        CFG_RX_FIRST_SAMPLE = 2'd1,
        CFG_RX_BIT_TICKS    = 2'd2,
        CFG_RX_REARM_TICKS  = 2'd3
    } cfg_idx_t;

    localparam logic [TICK_W-1:0] TX_BIT_TICKS_RST    = 16'd1667;
    localparam logic [TICK_W-1:0] RX_FIRST_SAMPLE_RST = 16'd2500;
    localparam logic [TICK_W-1:0] RX_BIT_TICKS_RST    = 16'd1667;
    localparam logic [TICK_W-1:0] RX_REARM_TICKS_RST  = 16'd1250;

    // a register value of zero counts as one tick
    function automatic logic [TICK_W-1:0] ticks_of(input logic [TICK_W-1:0] v);
        logic [TICK_W-1:0] r;
        r = (v == '0) ? TICK_W'(1) : v;
        return r;
    endfunction

endpackage

FILE: sv/uart_8n1_transceiver.sv
// ----------------------------------------------------------------------------
// uart_8n1_transceiver
// full-duplex 8n1 uart, one line tick per transaction
// ----------------------------------------------------------------------------
//  channel   dir  fields (low bit up)
//  s_axis    in   rx_level, tx_start, tx_byte
//  m_axis    out  tx_level, tx_accepted, tx_busy, rx_valid, rx_byte, rx_busy
//  cfg       in   index 0..3, 16-bit data, write only
//
//  one tick per cycle: the whole tick is computed in the accepting cycle and
//  lands in the output register, so a new tick is taken every cycle while
//  m_axis drains. a stalled output holds its result and stalls s_axis only
//  when the output register is full and not taken. rst_n clears all state
//  but the output data register and loads the default bit timings.
// ----------------------------------------------------------------------------
module uart_8n1_transceiver
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [uart_pkg::IN_W-1:0]         s_axis_tdata,   // rx_level, tx_start, tx_byte[7:0]

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [uart_pkg::OUT_W-1:0]        m_axis_tdata,   // tx_level, tx_accepted, tx_busy,
                                                              // rx_valid, rx_byte[7:0], rx_busy

    input  logic                              cfg_wr_en,
    input  logic [uart_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [uart_pkg::TICK_W-1:0]       cfg_wdata
);

    typedef enum logic [1:0] {
        TX_IDLE  = 2'd0,
        TX_START = 2'd1,
        TX_DATA  = 2'd2,
        TX_STOP  = 2'd3
    } tx_phase_t;

    typedef enum logic [1:0] {
        RX_IDLE   = 2'd0,
        RX_SAMPLE = 2'd1,
        RX_REARM  = 2'd2
    } rx_phase_t;

    logic [uart_pkg::TICK_W-1:0]   tx_bit_ticks_reg;
    logic [uart_pkg::TICK_W-1:0]   rx_first_ticks_reg;
    logic [uart_pkg::TICK_W-1:0]   rx_bit_ticks_reg;
    logic [uart_pkg::TICK_W-1:0]   rx_rearm_ticks_reg;

    tx_phase_t                     tx_phase_reg,    tx_phase_next;
    logic [uart_pkg::TICK_W-1:0]   tx_timer_reg,    tx_timer_next;
    logic [uart_pkg::BITCNT_W-1:0] tx_bits_reg,     tx_bits_next;
    logic [uart_pkg::BYTE_W-1:0]   tx_shift_reg,    tx_shift_next;

    rx_phase_t                     rx_phase_reg,    rx_phase_next;
    logic [uart_pkg::TICK_W-1:0]   rx_timer_reg,    rx_timer_next;
    logic [uart_pkg::BITCNT_W-1:0] rx_bits_reg,     rx_bits_next;
    logic [uart_pkg::BYTE_W-1:0]   rx_shift_reg,    rx_shift_next;
    logic                          rx_prev_reg,     rx_prev_next;

    logic                          out_valid_reg;
    logic [uart_pkg::OUT_W-1:0]    out_data_reg,    out_data_next;

    logic                          in_level;
    logic                          in_start;
    logic [uart_pkg::BYTE_W-1:0]   in_byte;
    logic                          accept;

    logic                          tx_level;
    logic                          tx_acc;
    logic                          tx_busy;
    logic                          rx_valid;
    logic [uart_pkg::BYTE_W-1:0]   rx_byte;
    logic                          rx_busy;

    assign in_level = s_axis_tdata[0];
    assign in_start = s_axis_tdata[1];
    assign in_byte  = s_axis_tdata[9:2];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // transmitter
    always_comb
    begin
        tx_phase_next = tx_phase_reg;
        tx_timer_next = tx_timer_reg;
        tx_bits_next  = tx_bits_reg;
        tx_shift_next = tx_shift_reg;
        tx_level      = 1'b1;
        tx_acc        = 1'b0;
        tx_busy       = 1'b0;

        if (tx_phase_reg == TX_IDLE && in_start)
        begin
            tx_acc        = 1'b1;
            tx_phase_next = TX_START;
            tx_timer_next = uart_pkg::ticks_of(tx_bit_ticks_reg);
            tx_bits_next  = uart_pkg::BITS_PER_BYTE;
            tx_shift_next = in_byte;
        end

        if (tx_phase_next != TX_IDLE)
        begin
            tx_busy = 1'b1;
            case (tx_phase_next)
                TX_START: tx_level = 1'b0;
                TX_DATA:  tx_level = tx_shift_next[0];
                default:  tx_level = 1'b1;
            endcase
            tx_timer_next = tx_timer_next - uart_pkg::TICK_W'(1);
            if (tx_timer_next == '0)
            begin
                case (tx_phase_next)
                    TX_START:
                    begin
                        tx_phase_next = TX_DATA;
                        tx_timer_next = uart_pkg::ticks_of(tx_bit_ticks_reg);
                    end
                    TX_DATA:
                    begin
                        tx_shift_next = {1'b0, tx_shift_next[uart_pkg::BYTE_W-1:1]};
                        tx_bits_next  = tx_bits_next - uart_pkg::BITCNT_W'(1);
                        if (tx_bits_next == '0)
                        begin
                            tx_phase_next = TX_STOP;
                        end
                        tx_timer_next = uart_pkg::ticks_of(tx_bit_ticks_reg);
                    end
                    default:
                    begin
                        tx_phase_next = TX_IDLE;
                    end
                endcase
            end
        end
    end

    // receiver
    always_comb
    begin
        rx_phase_next = rx_phase_reg;
        rx_timer_next = rx_timer_reg;
        rx_bits_next  = rx_bits_reg;
        rx_shift_next = rx_shift_reg;
        rx_prev_next  = in_level;
        rx_valid      = 1'b0;
        rx_byte       = '0;
        rx_busy       = 1'b0;

        case (rx_phase_reg)
            RX_SAMPLE, RX_REARM:
            begin
                rx_busy       = 1'b1;
                rx_timer_next = rx_timer_reg - uart_pkg::TICK_W'(1);
                if (rx_timer_next == '0)
                begin
                    if (rx_phase_reg == RX_SAMPLE)
                    begin
                        rx_shift_next = {in_level, rx_shift_reg[uart_pkg::BYTE_W-1:1]};
                        rx_bits_next  = rx_bits_reg - uart_pkg::BITCNT_W'(1);
                        if (rx_bits_next == '0)
                        begin
                            rx_valid      = 1'b1;
                            rx_byte       = rx_shift_next;
                            rx_phase_next = RX_REARM;
                            rx_timer_next = uart_pkg::ticks_of(rx_rearm_ticks_reg);
                        end
                        else
                        begin
                            rx_timer_next = uart_pkg::ticks_of(rx_bit_ticks_reg);
                        end
                    end
                    else
                    begin
                        rx_phase_next = RX_IDLE;
                    end
                end
            end
            default:
            begin
                rx_phase_next = RX_IDLE;
                if (rx_prev_reg && !in_level)
                begin
                    rx_phase_next = RX_SAMPLE;
                    rx_timer_next = uart_pkg::ticks_of(rx_first_ticks_reg);
                    rx_bits_next  = uart_pkg::BITS_PER_BYTE;
                    rx_shift_next = '0;
                    rx_busy       = 1'b1;
                end
            end
        endcase
    end

    assign out_data_next = {3'b000, rx_busy, rx_byte, rx_valid, tx_busy, tx_acc, tx_level};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_bit_ticks_reg   <= uart_pkg::TX_BIT_TICKS_RST;
            rx_first_ticks_reg <= uart_pkg::RX_FIRST_SAMPLE_RST;
            rx_bit_ticks_reg   <= uart_pkg::RX_BIT_TICKS_RST;
            rx_rearm_ticks_reg <= uart_pkg::RX_REARM_TICKS_RST;
        end
        else if (cfg_wr_en)
        begin
            case (uart_pkg::cfg_idx_t'(cfg_index))
                uart_pkg::CFG_TX_BIT_TICKS:    tx_bit_ticks_reg   <= cfg_wdata;
                uart_pkg::CFG_RX_FIRST_SAMPLE: rx_first_ticks_reg <= cfg_wdata;
                uart_pkg::CFG_RX_BIT_TICKS:    rx_bit_ticks_reg   <= cfg_wdata;
                uart_pkg::CFG_RX_REARM_TICKS:  rx_rearm_ticks_reg <= cfg_wdata;
                default:                       rx_rearm_ticks_reg <= rx_rearm_ticks_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_phase_reg  <= TX_IDLE;
            tx_timer_reg  <= '0;
            tx_bits_reg   <= '0;
            tx_shift_reg  <= '0;
            rx_phase_reg  <= RX_IDLE;
            rx_timer_reg  <= '0;
            rx_bits_reg   <= '0;
            rx_shift_reg  <= '0;
            rx_prev_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                tx_phase_reg <= tx_phase_next;
                tx_timer_reg <= tx_timer_next;
                tx_bits_reg  <= tx_bits_next;
                tx_shift_reg <= tx_shift_next;
                rx_phase_reg <= rx_phase_next;
                rx_timer_reg <= rx_timer_next;
                rx_bits_reg  <= rx_bits_next;
                rx_shift_reg <= rx_shift_next;
                rx_prev_reg  <= rx_prev_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule
